// ----- rtl/wss_pkg.sv -----
// Shared types, constants and helper functions for the weighted substring scorer.
package wss_pkg;

   // Sizing of the pattern set and the score.
   localparam int MAX_PATTERNS    = 4;
   localparam int MAX_PATTERN_LEN = 8;
   localparam int SCORE_BITS      = 16;
   localparam int HIST_LEN        = MAX_PATTERN_LEN - 1;
   localparam int PAT_IDX_BITS    = $clog2(MAX_PATTERNS + 1);
   localparam int LEN_BITS        = 4;
   localparam int SKIP_BITS       = 3;
   localparam int POS_BITS        = 4;
   localparam int WEIGHT_BITS     = 3;
   localparam int BONUS_BITS      = WEIGHT_BITS + 2;
   localparam int CSR_DATA_BITS   = 64;
   localparam int CSR_ADDR_BITS   = 6;
   localparam int CSR_IDX_BITS    = 3;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] CSR_TEXT_0  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TEXT_1  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TEXT_2  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TEXT_3  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LENGTHS = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COUNT   = 3'd5;

   // Field kind codes.
   localparam logic [1:0] KIND_NAME        = 2'd0;
   localparam logic [1:0] KIND_SYNOPSIS    = 2'd1;
   localparam logic [1:0] KIND_DESCRIPTION = 2'd2;

   localparam logic [WEIGHT_BITS-1:0] WEIGHT_NAME        = 3'd6;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_SYNOPSIS    = 3'd3;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_DESCRIPTION = 3'd2;

   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   typedef logic [7:0]             char_type;
   typedef logic [SCORE_BITS-1:0]  score_type;
   typedef logic [LEN_BITS-1:0]    len_type;
   typedef logic [SKIP_BITS-1:0]   skip_type;
   typedef logic [POS_BITS-1:0]    pos_type;
   typedef logic [WEIGHT_BITS-1:0] weight_type;
   typedef logic [MAX_PATTERN_LEN*8-1:0]      text_type;
   typedef logic [MAX_PATTERN_LEN-1:0][7:0]   taps_type;

   // Input word.
   typedef struct packed {
      logic [7:0] char_code;
      logic       has_char;
      logic [1:0] field_kind;
      logic       field_end;
      logic       record_end;
   } req_word_type;

   // Result word.
   typedef struct packed {
      logic [15:0] record_score;
      logic        keep_record;
   } rsp_word_type;

   // Per-word control broadcast to every pattern cell.
   typedef struct packed {
      logic       has_char;
      logic       field_close;
      logic       rec_end;
      weight_type weight;
      pos_type    pos;
      pos_type    pos_after;
   } cell_ctl_type;

   // Lowers ASCII capital letters.
   function automatic char_type lower_ascii(input char_type c);
      char_type r;
      r = c;
      if (c >= 8'd65 && c <= 8'd90) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   // Weight of a field kind; the unused kind weighs nothing.
   function automatic weight_type kind_weight(input logic [1:0] kind);
      weight_type w;
      unique case (kind)
         KIND_NAME:        w = WEIGHT_NAME;
         KIND_SYNOPSIS:    w = WEIGHT_SYNOPSIS;
         KIND_DESCRIPTION: w = WEIGHT_DESCRIPTION;
         default:          w = '0;
      endcase
      return w;
   endfunction

   // Saturating score addition.
   function automatic score_type sat_add(input score_type a, input score_type b);
      logic [SCORE_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SCORE_BITS] ? '1 : s[SCORE_BITS-1:0];
   endfunction

endpackage

// ----- rtl/wss_hist_cell.sv -----
// One byte cell of the character history chain.
module wss_hist_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  logic               clear,
   input  wss_pkg::char_type  din,
   output wss_pkg::char_type  dout
);

   wss_pkg::char_type byte_ff;
   wss_pkg::char_type byte_in;

   // Clearing at field close wins over the shift of the same word.
   always_comb begin
      byte_in = byte_ff;
      if (clear) begin
         byte_in = '0;
      end else if (shift) begin
         byte_in = din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign dout = byte_ff;

endmodule

// ----- rtl/wss_pat_cell.sv -----
// One pattern cell: matcher, skip counter, start flag and running subtotal.
module wss_pat_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   active,
   input  wss_pkg::cell_ctl_type  ctl,
   input  wss_pkg::text_type      pattern_text,
   input  wss_pkg::len_type       pat_len,
   input  wss_pkg::taps_type      taps,
   output wss_pkg::score_type     sub_final
);

   wss_pkg::skip_type  skip_ff, skip_in;
   logic               start_ff, start_in;
   wss_pkg::score_type sub_ff, sub_in;
   logic               match;
   logic               hit;
   wss_pkg::score_type sub_hit;
   wss_pkg::score_type bonus;
   logic [wss_pkg::LEN_BITS:0] pos_next;

   assign pos_next = {1'b0, ctl.pos} + {{wss_pkg::LEN_BITS{1'b0}}, 1'b1};

   // Compare the pattern against the newest bytes, last pattern byte on the current one.
   always_comb begin
      wss_pkg::char_type p;
      wss_pkg::len_type  back;
      match = (pat_len != '0) && (pos_next >= {1'b0, pat_len});
      for (int j = 0; j < wss_pkg::MAX_PATTERN_LEN; j++) begin
         p    = wss_pkg::lower_ascii(pattern_text[8*j +: 8]);
         back = pat_len - wss_pkg::LEN_BITS'(j + 1);
         if (wss_pkg::LEN_BITS'(j) < pat_len) begin
            if (p != taps[back[wss_pkg::SKIP_BITS-1:0]]) begin
               match = 1'b0;
            end
         end
      end
   end

   // Match bookkeeping for one word, then the whole-field bonus at field close.
   always_comb begin
      skip_in  = skip_ff;
      start_in = start_ff;
      hit      = 1'b0;
      if (active && ctl.has_char) begin
         if (skip_ff != '0) begin
            skip_in = skip_ff - 1'b1;
         end else if (match) begin
            hit     = 1'b1;
            skip_in = wss_pkg::SKIP_BITS'(pat_len - 1'b1);
            if (pos_next == {1'b0, pat_len}) begin
               start_in = 1'b1;
            end
         end
      end
      sub_hit = hit ? wss_pkg::sat_add(sub_ff, wss_pkg::SCORE_BITS'(ctl.weight)) : sub_ff;
      bonus   = wss_pkg::SCORE_BITS'({ctl.weight, 2'b00});
      sub_final = sub_hit;
      if (active && ctl.field_close && start_in && ({1'b0, ctl.pos_after} == {1'b0, pat_len})) begin
         sub_final = wss_pkg::sat_add(sub_hit, bonus);
      end
      if (ctl.field_close) begin
         skip_in  = '0;
         start_in = 1'b0;
      end
      sub_in = ctl.rec_end ? '0 : sub_final;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff  <= '0;
         start_ff <= 1'b0;
         sub_ff   <= '0;
      end else if (accept) begin
         skip_ff  <= skip_in;
         start_ff <= start_in;
         sub_ff   <= sub_in;
      end
   end

endmodule

// ----- rtl/weighted_substring_scorer_core.sv -----
// Top level: configuration registers, history chain, pattern cells and result stages.
// Throughput: one input word per cycle unless the result stages stall on rsp_ready; matching,
// skip and subtotal update in the accepting cycle. The word carrying record_end loads a snapshot
// register of the per-pattern subtotals, then the summing stage feeds the output register.
// Reset (synchronous, active high) clears configuration, history, pattern state and both
// result stages; no clearing pass is needed, so words are accepted right after reset.
module weighted_substring_scorer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  wss_pkg::req_word_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output wss_pkg::rsp_word_type               rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [wss_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [wss_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [wss_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);

   localparam int NP = wss_pkg::MAX_PATTERNS;
   localparam int NH = wss_pkg::HIST_LEN;

   // Configuration registers.
   wss_pkg::text_type text_ff [NP];
   logic [15:0]       lengths_ff;
   logic [2:0]        count_ff;

   logic [wss_pkg::CSR_IDX_BITS-1:0] csr_idx;
   logic                             csr_write;

   assign pready    = 1'b1;
   assign csr_idx   = paddr[wss_pkg::CSR_ADDR_BITS-1:3];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NP; k++) begin
            text_ff[k] <= '0;
         end
         lengths_ff <= '0;
         count_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_idx)
            wss_pkg::CSR_TEXT_0:  text_ff[0] <= pwdata;
            wss_pkg::CSR_TEXT_1:  text_ff[1] <= pwdata;
            wss_pkg::CSR_TEXT_2:  text_ff[2] <= pwdata;
            wss_pkg::CSR_TEXT_3:  text_ff[3] <= pwdata;
            wss_pkg::CSR_LENGTHS: lengths_ff <= pwdata[15:0];
            wss_pkg::CSR_COUNT:   count_ff   <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   // Register readback.
   always_comb begin
      unique case (csr_idx)
         wss_pkg::CSR_TEXT_0:  prdata = text_ff[0];
         wss_pkg::CSR_TEXT_1:  prdata = text_ff[1];
         wss_pkg::CSR_TEXT_2:  prdata = text_ff[2];
         wss_pkg::CSR_TEXT_3:  prdata = text_ff[3];
         wss_pkg::CSR_LENGTHS: prdata = {48'd0, lengths_ff};
         wss_pkg::CSR_COUNT:   prdata = {61'd0, count_ff};
         default:              prdata = '0;
      endcase
   end

   // Clamped lengths and active mask.
   wss_pkg::len_type pat_len [NP];
   logic [NP-1:0]    active;
   logic [2:0]       count_eff;

   assign count_eff = (count_ff > 3'(NP)) ? 3'(NP) : count_ff;

   always_comb begin
      wss_pkg::len_type raw;
      for (int k = 0; k < NP; k++) begin
         raw        = lengths_ff[4*k +: 4];
         pat_len[k] = (raw > 4'(wss_pkg::MAX_PATTERN_LEN)) ?
                      4'(wss_pkg::MAX_PATTERN_LEN) : raw;
         active[k]  = 3'(k) < count_eff;
      end
   end

   // Handshakes and result stage movement.
   logic s_valid_ff, s_valid_in;
   logic o_valid_ff, o_valid_in;
   logic s_move;
   logic accept;

   assign s_move    = s_valid_ff && (!o_valid_ff || rsp_ready);
   assign req_ready = !s_valid_ff || s_move;
   assign accept    = req_valid && req_ready;

   // Per-word control shared by all cells.
   wss_pkg::char_type     cur;
   wss_pkg::cell_ctl_type ctl;
   wss_pkg::pos_type      pos_ff, pos_in;

   assign cur = wss_pkg::lower_ascii(req_data.char_code);

   always_comb begin
      ctl.has_char    = req_data.has_char;
      ctl.field_close = req_data.field_end || req_data.record_end;
      ctl.rec_end     = req_data.record_end;
      ctl.weight      = wss_pkg::kind_weight(req_data.field_kind);
      ctl.pos         = pos_ff;
      ctl.pos_after   = pos_ff;
      if (req_data.has_char && pos_ff != wss_pkg::POS_MAX) begin
         ctl.pos_after = pos_ff + 1'b1;
      end
      pos_in = ctl.field_close ? '0 : ctl.pos_after;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
      end
   end

   // History chain: each cell passes its byte to the next on every character word; a field close clears it.
   wss_pkg::char_type hist [NH];
   wss_pkg::taps_type taps;

   for (genvar i = 0; i < NH; i++) begin : g_hist
      wss_hist_cell u_hist (
         .clock (clock),
         .reset (reset),
         .shift (accept && req_data.has_char),
         .clear (accept && ctl.field_close),
         .din   ((i == 0) ? cur : hist[(i == 0) ? 0 : i - 1]),
         .dout  (hist[i])
      );
   end

   always_comb begin
      taps[0] = cur;
      for (int b = 1; b < wss_pkg::MAX_PATTERN_LEN; b++) begin
         taps[b] = hist[b-1];
      end
   end

   // Pattern cells.
   wss_pkg::score_type sub_final [NP];

   for (genvar k = 0; k < NP; k++) begin : g_pat
      wss_pat_cell u_pat (
         .clock        (clock),
         .reset        (reset),
         .accept       (accept),
         .active       (active[k]),
         .ctl          (ctl),
         .pattern_text (text_ff[k]),
         .pat_len      (pat_len[k]),
         .taps         (taps),
         .sub_final    (sub_final[k])
      );
   end

   // Snapshot stage: subtotals of the closing record.
   wss_pkg::score_type s_sub_ff [NP];
   logic [NP-1:0]      s_active_ff;
   logic               s_load;

   assign s_load     = accept && req_data.record_end;
   assign s_valid_in = s_load || (s_valid_ff && !s_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s_load) begin
         for (int k = 0; k < NP; k++) begin
            s_sub_ff[k] <= sub_final[k];
         end
         s_active_ff <= active;
      end
   end

   // Sum stage: saturating total, zeroed when any active pattern scored nothing.
   wss_pkg::rsp_word_type sum_word;
   wss_pkg::rsp_word_type o_word_ff;

   always_comb begin
      wss_pkg::score_type total;
      logic               zero;
      total = '0;
      zero  = 1'b0;
      for (int k = 0; k < NP; k++) begin
         if (s_active_ff[k]) begin
            if (s_sub_ff[k] == '0) begin
               zero = 1'b1;
            end
            total = wss_pkg::sat_add(total, s_sub_ff[k]);
         end
      end
      if (zero) begin
         total = '0;
      end
      sum_word.record_score = total;
      sum_word.keep_record  = (s_active_ff == '0) || (total != '0);
   end

   // Output register.
   assign o_valid_in = s_move || (o_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s_move) begin
         o_word_ff <= sum_word;
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_data  = o_word_ff;

endmodule

// ----- bench/weighted_substring_scorer_core_tb.sv -----
// Self-checking testbench for the weighted substring scorer core.
module weighted_substring_scorer_core_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 220;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 4;

   // Field kind that carries no weight.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // Tracks the expected score of each record from the words accepted so far.
   class score_board;
      wss_pkg::text_type     pat_text [wss_pkg::MAX_PATTERNS];
      logic [15:0]           pat_lens;
      logic [2:0]            pat_cnt;
      wss_pkg::char_type     history [wss_pkg::HIST_LEN];
      wss_pkg::skip_type     skip_left [wss_pkg::MAX_PATTERNS];
      wss_pkg::score_type    subtotal [wss_pkg::MAX_PATTERNS];
      bit                    start_hit [wss_pkg::MAX_PATTERNS];
      wss_pkg::pos_type      field_pos;
      wss_pkg::rsp_word_type expected_q [$];
      int                    errors;

      function new();
         foreach (pat_text[k]) begin
            pat_text[k] = '0;
            subtotal[k] = '0;
         end
         pat_lens = '0;
         pat_cnt  = '0;
         errors   = 0;
         clear_field();
      endfunction

      function void clear_field();
         foreach (history[i]) history[i] = '0;
         foreach (skip_left[k]) begin
            skip_left[k] = '0;
            start_hit[k] = 1'b0;
         end
         field_pos = '0;
      endfunction

      function wss_pkg::char_type fold_case(wss_pkg::char_type c);
         if (c >= 8'h41 && c <= 8'h5a) begin
            return c + 8'h20;
         end
         return c;
      endfunction

      function wss_pkg::score_type clamp_add(wss_pkg::score_type a, wss_pkg::score_type b);
         logic [wss_pkg::SCORE_BITS:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[wss_pkg::SCORE_BITS] ? '1 : s[wss_pkg::SCORE_BITS-1:0];
      endfunction

      function wss_pkg::score_type weight_of(logic [1:0] kind);
         case (kind)
            wss_pkg::KIND_NAME: begin
               return wss_pkg::score_type'(wss_pkg::WEIGHT_NAME);
            end
            wss_pkg::KIND_SYNOPSIS: begin
               return wss_pkg::score_type'(wss_pkg::WEIGHT_SYNOPSIS);
            end
            wss_pkg::KIND_DESCRIPTION: begin
               return wss_pkg::score_type'(wss_pkg::WEIGHT_DESCRIPTION);
            end
            default: begin
               return '0;
            end
         endcase
      endfunction

      // Lengths above the maximum are clipped to it.
      function int eff_len(int k);
         int l;
         l = int'(pat_lens[4*k +: 4]);
         return (l > wss_pkg::MAX_PATTERN_LEN) ? wss_pkg::MAX_PATTERN_LEN : l;
      endfunction

      function int active_patterns();
         return (int'(pat_cnt) > wss_pkg::MAX_PATTERNS) ?
                wss_pkg::MAX_PATTERNS : int'(pat_cnt);
      endfunction

      // True when pattern k ends with the current byte.
      function bit ends_match(int k, int len, wss_pkg::char_type cur);
         wss_pkg::char_type p;
         wss_pkg::char_type c;
         int back;
         if (len == 0 || int'(field_pos) + 1 < len) begin
            return 1'b0;
         end
         for (int j = 0; j < len; j++) begin
            p = fold_case(pat_text[k][8*j +: 8]);
            back = len - 1 - j;
            c = (back == 0) ? cur : history[back-1];
            if (p != c) begin
               return 1'b0;
            end
         end
         return 1'b1;
      endfunction

      function void set_register(logic [wss_pkg::CSR_IDX_BITS-1:0] idx, logic [63:0] value);
         case (idx)
            wss_pkg::CSR_TEXT_0, wss_pkg::CSR_TEXT_1,
            wss_pkg::CSR_TEXT_2, wss_pkg::CSR_TEXT_3: begin
               pat_text[idx] = value;
            end
            wss_pkg::CSR_LENGTHS: begin
               pat_lens = value[15:0];
            end
            wss_pkg::CSR_COUNT: begin
               pat_cnt = value[2:0];
            end
            default: begin
            end
         endcase
      endfunction

      // Advances the predicted state by one accepted word.
      function void note_input(wss_pkg::req_word_type word);
         wss_pkg::char_type     cur;
         wss_pkg::score_type    w;
         wss_pkg::score_type    total;
         bit                    zero;
         int                    n;
         int                    len;
         wss_pkg::rsp_word_type result;
         cur = fold_case(word.char_code);
         w   = weight_of(word.field_kind);
         n   = active_patterns();

         // The byte is taken before any close on the same word.
         if (word.has_char) begin
            for (int k = 0; k < n; k++) begin
               len = eff_len(k);
               if (skip_left[k] != 0) begin
                  skip_left[k] = skip_left[k] - 1'b1;
               end else if (ends_match(k, len, cur)) begin
                  subtotal[k]  = clamp_add(subtotal[k], w);
                  skip_left[k] = wss_pkg::skip_type'(len - 1);
                  if (int'(field_pos) + 1 == len) begin
                     start_hit[k] = 1'b1;
                  end
               end
            end
            for (int i = wss_pkg::HIST_LEN - 1; i > 0; i--) begin
               history[i] = history[i-1];
            end
            history[0] = cur;
            if (field_pos != wss_pkg::POS_MAX) begin
               field_pos = field_pos + 1'b1;
            end
         end

         // A match that spans the whole field earns the bonus at close.
         if (word.field_end || word.record_end) begin
            for (int k = 0; k < n; k++) begin
               if (start_hit[k] && int'(field_pos) == eff_len(k)) begin
                  subtotal[k] = clamp_add(subtotal[k], w << 2);
               end
            end
            clear_field();
         end

         if (word.record_end) begin
            total = '0;
            zero  = 1'b0;
            for (int k = 0; k < n; k++) begin
               if (subtotal[k] == 0) begin
                  zero = 1'b1;
               end
               total = clamp_add(total, subtotal[k]);
            end
            if (zero) begin
               total = '0;
            end
            result.record_score = total;
            result.keep_record  = (n == 0) || (total != 0);
            expected_q.insert(expected_q.size(), result);
            foreach (subtotal[k]) subtotal[k] = '0;
         end
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_result(wss_pkg::rsp_word_type got);
         wss_pkg::rsp_word_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word score %0d keep %0d",
                                      got.record_score, got.keep_record));
            return;
         end
         want = expected_q.pop_front();
         if (got.record_score !== want.record_score) begin
            report_mismatch($sformatf("record_score %0d, expected %0d",
                                      got.record_score, want.record_score));
         end
         if (got.keep_record !== want.keep_record) begin
            report_mismatch($sformatf("keep_record %0d, expected %0d",
                                      got.keep_record, want.keep_record));
         end
      endtask
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   wss_pkg::req_word_type             req_data = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   wss_pkg::rsp_word_type             rsp_data;
   logic                              psel = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite = 1'b0;
   logic [wss_pkg::CSR_ADDR_BITS-1:0] paddr = '0;
   logic [wss_pkg::CSR_DATA_BITS-1:0] pwdata = '0;
   logic [wss_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                              pready;

   score_board scores = new();
   int         items_sent = 0;
   int         cycle_count = 0;
   int         send_gap_pct = 0;
   int         recv_stall_pct = 0;
   bit         quiet = 1'b0;
   bit         hold_trigger = 1'b0;

   weighted_substring_scorer_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Run limit in case the block hangs.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("weighted_substring_scorer_core_tb: errors");
      $finish;
   end

   // Result side: checks each word and stalls in bursts or one long hold.
   initial begin : result_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            scores.check_result(rsp_data);
         end
         if (hold_trigger) begin
            hold_trigger = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < recv_stall_pct) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic wss_pkg::req_word_type pack_word(wss_pkg::char_type c, bit has,
                                                       logic [1:0] kind, bit fe, bit re);
      wss_pkg::req_word_type word;
      word.char_code  = c;
      word.has_char   = has;
      word.field_kind = kind;
      word.field_end  = fe;
      word.record_end = re;
      return word;
   endfunction

   function automatic wss_pkg::char_type alpha_char();
      wss_pkg::char_type c;
      c = 8'h61 + wss_pkg::char_type'($urandom_range(0, 2));
      if ($urandom_range(0, 1) != 0) begin
         c = c - 8'h20;
      end
      return c;
   endfunction

   function automatic logic [63:0] random_text();
      logic [63:0] t;
      if ($urandom_range(0, 7) == 0) begin
         t = {$urandom, $urandom};
      end else begin
         for (int j = 0; j < 8; j++) begin
            t[8*j +: 8] = alpha_char();
         end
      end
      return t;
   endfunction

   // Copies the active bytes of pattern k into a field, letters in random case.
   function automatic void append_pattern(ref wss_pkg::char_type body[$], input int k);
      wss_pkg::char_type c;
      for (int j = 0; j < scores.eff_len(k); j++) begin
         c = scores.pat_text[k][8*j +: 8];
         if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7a && $urandom_range(0, 1) != 0) begin
            c = c ^ 8'h20;
         end
         body.insert(body.size(), c);
      end
   endfunction

   // Offers one word after an optional idle burst and waits for acceptance.
   task automatic send_word(input wss_pkg::req_word_type word);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < send_gap_pct) begin
         gap = $urandom_range(1, 16);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      do @(posedge clock); while (!req_ready);
      scores.note_input(word);
      items_sent++;
   endtask

   task automatic write_csr(input logic [wss_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      scores.set_register(idx, value);
   endtask

   task automatic load_setup(input logic [63:0] t0, input logic [63:0] t1,
                             input logic [63:0] t2, input logic [63:0] t3,
                             input logic [15:0] lens, input logic [2:0] cnt);
      write_csr(wss_pkg::CSR_TEXT_0, t0);
      write_csr(wss_pkg::CSR_TEXT_1, t1);
      write_csr(wss_pkg::CSR_TEXT_2, t2);
      write_csr(wss_pkg::CSR_TEXT_3, t3);
      write_csr(wss_pkg::CSR_LENGTHS, 64'(lens));
      write_csr(wss_pkg::CSR_COUNT, 64'(cnt));
   endtask

   // Mostly short patterns, with empty and overlong ones now and then.
   task automatic random_setup();
      logic [15:0] lens;
      logic [2:0]  cnt;
      int          pick;
      for (int k = 0; k < wss_pkg::MAX_PATTERNS; k++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            lens[4*k +: 4] = 4'd0;
         end else if (pick < 13) begin
            lens[4*k +: 4] = 4'($urandom_range(1, 3));
         end else if (pick < 16) begin
            lens[4*k +: 4] = 4'($urandom_range(4, 8));
         end else begin
            lens[4*k +: 4] = 4'($urandom_range(9, 15));
         end
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         cnt = 3'd0;
      end else if (pick < 7) begin
         cnt = 3'($urandom_range(1, 4));
      end else begin
         cnt = 3'($urandom_range(5, 7));
      end
      load_setup(random_text(), random_text(), random_text(), random_text(), lens, cnt);
   endtask

   // One record of fields; tidy records run name, synopsis, description in order.
   task automatic send_record(input bit tidy);
      wss_pkg::char_type     body[$];
      int                    fields;
      int                    n;
      int                    flen;
      int                    pick;
      logic [1:0]            kind;
      bit                    last_field;
      bit                    close_on_char;
      bit                    skip_close;
      wss_pkg::req_word_type word;
      n = scores.active_patterns();
      fields = tidy ? 3 : $urandom_range(1, 4);
      for (int f = 0; f < fields; f++) begin
         kind = tidy ? 2'(f) : 2'($urandom_range(0, 3));
         last_field = (f == fields - 1);
         body.delete();
         if (n != 0 && $urandom_range(0, 9) == 0) begin
            append_pattern(body, $urandom_range(0, n - 1));
         end else begin
            flen = $urandom_range(0, 12);
            while (body.size() < flen) begin
               pick = $urandom_range(0, 9);
               if (pick < 6) begin
                  body.insert(body.size(), alpha_char());
               end else if (pick < 8 && n != 0) begin
                  append_pattern(body, $urandom_range(0, n - 1));
               end else begin
                  body.insert(body.size(), wss_pkg::char_type'($urandom));
               end
            end
         end
         skip_close    = !tidy && !last_field && $urandom_range(0, 3) == 0;
         close_on_char = body.size() != 0 && $urandom_range(0, 2) != 0;
         for (int i = 0; i < body.size(); i++) begin
            word = pack_word(body[i], 1'b1, kind, 1'b0, 1'b0);
            if ($urandom_range(0, 29) == 0) begin
               word.field_kind = 2'($urandom_range(0, 3));
            end
            if (i == body.size() - 1 && close_on_char && !skip_close) begin
               word.record_end = last_field;
               word.field_end  = !last_field || $urandom_range(0, 1) != 0;
            end
            send_word(word);
         end
         if (!skip_close && !close_on_char) begin
            send_word(pack_word(wss_pkg::char_type'($urandom), 1'b0, kind,
                                !last_field || $urandom_range(0, 1) != 0, last_field));
         end
      end
   endtask

   // Words with every field random.
   task automatic send_noise(input int count);
      wss_pkg::req_word_type word;
      for (int i = 0; i < count; i++) begin
         word.char_code  = wss_pkg::char_type'($urandom);
         word.has_char   = 1'($urandom);
         word.field_kind = 2'($urandom);
         word.field_end  = $urandom_range(0, 3) == 0;
         word.record_end = $urandom_range(0, 9) == 0;
         send_word(word);
      end
   endtask

   // Waits until every expected word has arrived and the pipeline is empty.
   task automatic drain();
      req_valid <= 1'b0;
      while (scores.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin : stimulus
      int phase_goal;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // With no active patterns every record is kept at score zero.
      send_word(pack_word("Q", 1'b1, wss_pkg::KIND_NAME, 1'b1, 1'b0));
      send_word(pack_word("x", 1'b1, wss_pkg::KIND_SYNOPSIS, 1'b0, 1'b0));
      send_word(pack_word(8'h00, 1'b0, wss_pkg::KIND_DESCRIPTION, 1'b1, 1'b1));
      drain();

      // Patterns "ab" and "Z" with stray bytes past its length.
      load_setup(64'h6261, 64'hFFFF_FFFF_FFFF_FF5A, '1, '0, 16'h0812, 3'd2);
      // Whole-field match in the name, marker-only close on the synopsis.
      send_word(pack_word("A", 1'b1, wss_pkg::KIND_NAME, 1'b0, 1'b0));
      send_word(pack_word("B", 1'b1, wss_pkg::KIND_NAME, 1'b1, 1'b0));
      send_word(pack_word("z", 1'b1, wss_pkg::KIND_SYNOPSIS, 1'b0, 1'b0));
      send_word(pack_word("Z", 1'b1, wss_pkg::KIND_SYNOPSIS, 1'b0, 1'b0));
      send_word(pack_word(8'hFF, 1'b0, wss_pkg::KIND_SYNOPSIS, 1'b1, 1'b0));
      // Byte extremes around the capital range, a weightless match, and a byte
      // that closes the record.
      send_word(pack_word(8'h00, 1'b1, wss_pkg::KIND_DESCRIPTION, 1'b0, 1'b0));
      send_word(pack_word(8'hFF, 1'b1, wss_pkg::KIND_DESCRIPTION, 1'b0, 1'b0));
      send_word(pack_word("@", 1'b1, wss_pkg::KIND_DESCRIPTION, 1'b0, 1'b0));
      send_word(pack_word("[", 1'b1, wss_pkg::KIND_DESCRIPTION, 1'b0, 1'b0));
      send_word(pack_word("a", 1'b1, wss_pkg::KIND_DESCRIPTION, 1'b0, 1'b0));
      send_word(pack_word("b", 1'b1, KIND_UNUSED, 1'b0, 1'b0));
      send_word(pack_word("z", 1'b1, wss_pkg::KIND_DESCRIPTION, 1'b0, 1'b1));
      // One pattern scoring zero zeroes the record; then an empty record.
      send_word(pack_word("z", 1'b1, KIND_UNUSED, 1'b1, 1'b1));
      send_word(pack_word(8'h7F, 1'b0, wss_pkg::KIND_NAME, 1'b0, 1'b1));
      // Kind changes inside a field: the match and the bonus take different weights.
      send_word(pack_word("a", 1'b1, wss_pkg::KIND_NAME, 1'b0, 1'b0));
      send_word(pack_word("B", 1'b1, wss_pkg::KIND_SYNOPSIS, 1'b0, 1'b0));
      send_word(pack_word(8'h80, 1'b0, wss_pkg::KIND_DESCRIPTION, 1'b1, 1'b0));
      send_word(pack_word("Z", 1'b1, wss_pkg::KIND_NAME, 1'b1, 1'b1));
      drain();

      phase_goal = items_sent;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               // All-ones and all-zero texts, one length past the maximum.
               load_setup('1, '0, '1, '0, 16'h0F18, 3'd3);
            end
            4: begin
               // Every length and the count past their maximum.
               load_setup(random_text(), random_text(), random_text(), random_text(),
                          16'hFFFF, 3'd7);
            end
            default: begin
               random_setup();
            end
         endcase
         quiet = (ph == PHASES - 1);
         if (ph == 2 || ph == 3) begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end else begin
            send_gap_pct   = $urandom_range(0, 3) * 10;
            recv_stall_pct = $urandom_range(0, 3) * 10;
         end
         if (ph == 3) begin
            hold_trigger = 1'b1;
         end
         phase_goal += PHASE_ITEMS;
         while (items_sent < phase_goal) begin
            if ($urandom_range(0, 9) < 8) begin
               send_record($urandom_range(0, 3) != 0);
            end else begin
               send_noise($urandom_range(1, 6));
            end
         end
         send_word(pack_word(wss_pkg::char_type'($urandom), 1'b0, wss_pkg::KIND_NAME,
                             1'b0, 1'b1));
         drain();
      end

      if (scores.errors == 0) begin
         $display("weighted_substring_scorer_core_tb: clean");
      end else begin
         $display("weighted_substring_scorer_core_tb: errors");
      end
      $finish;
   end

endmodule
